@@ src/dtr_pkg.sv @@
// ----------------------------------------------------------------------------
// dtr_pkg
// Shared types, codes, font and masks for the digit transition renderer.
// ----------------------------------------------------------------------------
package dtr_pkg;

   // Widths of the item fields
   localparam int FUNC_W  = 3;
   localparam int PANEL_W = 2;
   localparam int DIGIT_W = 4;
   localparam int FRAME_W = 4;
   localparam int ROW_W   = 8;
   localparam int ROWS    = 6;

   // Stream widths, rounded up to whole bytes
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 56;

   localparam int PANEL_COUNT_DEFAULT = 4;

   // Transition kinds
   localparam logic [FUNC_W-1:0] FUNC_SCROLL  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_EXPLODE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DECAY   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_MELT    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_WIPER   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_BLEND   = 3'd5;

   // Explode sparks
   localparam logic [ROW_W-1:0] PIX_CENTER = 8'h10;
   localparam logic [ROW_W-1:0] PIX_PAIR   = 8'h28;
   localparam logic [ROW_W-1:0] PIX_WIDE   = 8'h44;
   localparam logic [ROW_W-1:0] PIX_ALL    = 8'h7C;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [PANEL_W-1:0] panel;
      logic [DIGIT_W-1:0] old_value;
      logic [DIGIT_W-1:0] new_value;
      logic [FRAME_W-1:0] frame_number;
   } req_item_type;

   typedef struct packed {
      logic [PANEL_W-1:0]          panel_out;
      logic [ROWS-1:0][ROW_W-1:0]  rows;      // rows[0] is display row 1
   } rsp_item_type;

   // 5x6 digit font, columns in bits 6 to 2
   localparam logic [ROW_W-1:0] GLYPHS [10][6] = '{
      '{8'h38, 8'h44, 8'h44, 8'h44, 8'h44, 8'h38},
      '{8'h10, 8'h30, 8'h10, 8'h10, 8'h10, 8'h38},
      '{8'h38, 8'h44, 8'h08, 8'h10, 8'h20, 8'h7C},
      '{8'h38, 8'h44, 8'h18, 8'h04, 8'h44, 8'h38},
      '{8'h08, 8'h18, 8'h28, 8'h7C, 8'h08, 8'h08},
      '{8'h7C, 8'h40, 8'h78, 8'h04, 8'h44, 8'h38},
      '{8'h38, 8'h40, 8'h78, 8'h44, 8'h44, 8'h38},
      '{8'h7C, 8'h04, 8'h08, 8'h10, 8'h10, 8'h10},
      '{8'h38, 8'h44, 8'h38, 8'h44, 8'h44, 8'h38},
      '{8'h38, 8'h44, 8'h44, 8'h3C, 8'h04, 8'h38}
   };

   // Font row of a digit; blank digits and rows off the glyph draw nothing
   function automatic logic [ROW_W-1:0] glyph_row(input logic [DIGIT_W-1:0] digit,
                                                  input logic [2:0] idx);
      logic [ROW_W-1:0] pix;
      pix = '0;
      if (digit <= 4'd9 && idx <= 3'd5) begin
         pix = GLYPHS[digit][idx];
      end
      return pix;
   endfunction

   // Decay mask for frames 1 to 4
   function automatic logic [ROW_W-1:0] decay_mask(input logic [1:0] step);
      logic [ROW_W-1:0] m;
      case (step)
         2'd0:    m = 8'h54;
         2'd1:    m = 8'h14;
         2'd2:    m = 8'h10;
         default: m = 8'h00;
      endcase
      return m;
   endfunction

   // Blend mask, densest first
   function automatic logic [ROW_W-1:0] fade_mask(input logic [1:0] step);
      logic [ROW_W-1:0] m;
      case (step)
         2'd0:    m = 8'h7C;
         2'd1:    m = 8'h54;
         2'd2:    m = 8'h10;
         default: m = 8'h00;
      endcase
      return m;
   endfunction

   // Pixel bit of font column 0 (left) to 4 (right)
   function automatic logic [ROW_W-1:0] column_bit(input logic [2:0] col);
      logic [ROW_W-1:0] b;
      case (col)
         3'd0:    b = 8'h40;
         3'd1:    b = 8'h20;
         3'd2:    b = 8'h10;
         3'd3:    b = 8'h08;
         3'd4:    b = 8'h04;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

@@ src/dtr_render.sv @@
// ----------------------------------------------------------------------------
// dtr_render
// Frame logic: draws the six digit rows of one panel for one animation frame.
// ----------------------------------------------------------------------------
module dtr_render #(
   parameter int PANEL_COUNT = dtr_pkg::PANEL_COUNT_DEFAULT
) (
   input  dtr_pkg::req_item_type item,
   output dtr_pkg::rsp_item_type result
);

   logic [dtr_pkg::ROW_W-1:0]   go [dtr_pkg::ROWS];
   logic [dtr_pkg::ROW_W-1:0]   gn [dtr_pkg::ROWS];
   logic [dtr_pkg::ROWS-1:0][dtr_pkg::ROW_W-1:0] rows;
   logic [dtr_pkg::FRAME_W-1:0] frame;
   logic [dtr_pkg::FRAME_W-1:0] fe;
   logic [dtr_pkg::FRAME_W-1:0] fb;
   logic [dtr_pkg::FRAME_W-1:0] wpos;
   logic [dtr_pkg::ROW_W-1:0]   incoming_cols;
   logic [dtr_pkg::ROW_W-1:0]   outgoing_cols;
   logic [dtr_pkg::ROW_W-1:0]   bar_mask;
   logic [4:0]                  diff;
   logic [4:0]                  target;
   logic [2:0]                  melt_start;
   logic                        panel_ok;

   assign frame    = item.frame_number;
   assign panel_ok = (32'(item.panel) < PANEL_COUNT);

   // Fetch both digits' font rows
   always_comb begin
      for (int k = 0; k < dtr_pkg::ROWS; k++) begin
         go[k] = dtr_pkg::glyph_row(item.old_value, 3'(k));
         gn[k] = dtr_pkg::glyph_row(item.new_value, 3'(k));
      end
   end

   // Frame zero counts as frame one; blend saturates at seven
   assign fe = (frame == '0) ? 4'd1 : frame;
   assign fb = (fe > 4'd7) ? 4'd7 : fe;

   // Melt refill start row for frames past four
   always_comb begin
      case (fe)
         4'd5:    melt_start = 3'd5;
         4'd6:    melt_start = 3'd3;
         4'd7:    melt_start = 3'd1;
         default: melt_start = 3'd0;
      endcase
   end

   // Wiper masks: new digit left of the bar, old digit right of it
   assign wpos = fe - 4'd1;
   always_comb begin
      incoming_cols = '0;
      outgoing_cols = '0;
      bar_mask      = '0;
      if (fe <= 4'd5) begin
         for (int c = 0; c < 5; c++) begin
            if (4'(c) < wpos) begin
               incoming_cols = incoming_cols | dtr_pkg::column_bit(3'(c));
            end else if (4'(c) > wpos) begin
               outgoing_cols = outgoing_cols | dtr_pkg::column_bit(3'(c));
            end
         end
         bar_mask = dtr_pkg::column_bit(wpos[2:0]);
      end else begin
         incoming_cols = dtr_pkg::PIX_ALL;
      end
   end

   // Draw each display row
   always_comb begin
      rows   = '0;
      diff   = '0;
      target = '0;
      for (int j = 0; j < dtr_pkg::ROWS; j++) begin
         case (item.func)
            dtr_pkg::FUNC_SCROLL: begin
               if ({1'b0, frame} <= 5'(j)) begin
                  diff    = 5'(j) - {1'b0, frame};
                  rows[j] = go[diff[2:0]];
               end else if ({1'b0, frame} <= 5'(j + 6)) begin
                  diff    = 5'(j + 6) - {1'b0, frame};
                  rows[j] = gn[diff[2:0]];
               end
            end
            dtr_pkg::FUNC_EXPLODE: begin
               case (frame)
                  4'd1: if (j >= 1 && j <= 4) rows[j] = go[j];
                  4'd2: if (j == 2 || j == 3) rows[j] = go[j];
                  4'd3: if (j == 2 || j == 3) rows[j] = dtr_pkg::PIX_CENTER;
                  4'd4: begin
                     if (j == 1 || j == 4) rows[j] = dtr_pkg::PIX_CENTER;
                     if (j == 2 || j == 3) rows[j] = dtr_pkg::PIX_PAIR;
                  end
                  4'd5: begin
                     if (j == 0 || j == 5) rows[j] = dtr_pkg::PIX_CENTER;
                     if (j == 1 || j == 4) rows[j] = dtr_pkg::PIX_PAIR;
                     if (j == 2 || j == 3) rows[j] = dtr_pkg::PIX_WIDE;
                  end
                  4'd6: if (j == 0 || j == 5) rows[j] = dtr_pkg::PIX_WIDE;
                  default: rows[j] = '0;
               endcase
            end
            dtr_pkg::FUNC_DECAY: begin
               if (fe <= 4'd4) begin
                  rows[j] = go[j] & dtr_pkg::decay_mask(wpos[1:0]);
               end else begin
                  rows[j] = gn[j];
               end
            end
            dtr_pkg::FUNC_MELT: begin
               if (fe <= 4'd4) begin
                  // pile each old row down, collecting at the bottom row
                  for (int i = 0; i < dtr_pkg::ROWS; i++) begin
                     target = 5'(i) + {1'b0, wpos};
                     if (target > 5'd5) target = 5'd5;
                     if (target == 5'(j)) rows[j] = rows[j] | go[i];
                  end
               end else if (3'(j) >= melt_start) begin
                  rows[j] = gn[j];
               end
            end
            dtr_pkg::FUNC_WIPER: begin
               rows[j] = (go[j] & outgoing_cols) | (gn[j] & incoming_cols) | bar_mask;
            end
            dtr_pkg::FUNC_BLEND: begin
               if (fb <= 4'd3) begin
                  rows[j] = go[j] & dtr_pkg::fade_mask(2'(fb - 4'd1));
               end else if (fb >= 4'd5) begin
                  rows[j] = gn[j] & dtr_pkg::fade_mask(2'(4'd7 - fb));
               end
            end
            default: rows[j] = '0;
         endcase
      end
   end

   // Blank panels that are not fitted
   assign result.panel_out = item.panel;
   assign result.rows      = panel_ok ? rows : '0;

endmodule

@@ src/digit_transition_renderer_core.sv @@
// ----------------------------------------------------------------------------
// digit_transition_renderer_core
// Renders one frame of a digit transition on an 8x8 LED panel.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per frame request. req_tuser carries the transition
//   kind, req_tdata the panel, old digit, new digit and frame number.
//   rsp channel: one beat per request, in order, carrying the panel index and
//   the six pixel rows of that frame.
//   A request accepted at a clock edge lands in the input register and moves
//   on to the result register, which drives rsp_tvalid, once that register
//   is free or being drained.
//   Throughput: one beat per cycle while the receiver does not stall, set by
//   the single-pass row logic between the input register and the result register.
//   Reset clears both valid flags; no beat is held afterwards.
//   When the receiver stalls, the result register holds its beat and the
//   input register fills once more; req_tready then drops until rsp moves.
// ----------------------------------------------------------------------------
module digit_transition_renderer_core #(
   parameter int PANEL_COUNT = dtr_pkg::PANEL_COUNT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [1:0] panel, [5:2] old_value, [9:6] new_value, [13:10] frame_number
   input  logic [dtr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [2:0] func
   input  logic [dtr_pkg::FUNC_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] panel_out, [9:2] row1, [17:10] row2, [25:18] row3,
   // [33:26] row4, [41:34] row5, [49:42] row6
   output logic [dtr_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   dtr_pkg::req_item_type req_item;
   dtr_pkg::req_item_type item_ff;
   dtr_pkg::rsp_item_type result;
   dtr_pkg::rsp_item_type result_ff;
   logic                  item_valid_ff;
   logic                  item_valid_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  advance;
   logic                  req_take;

   // Unpack the request beat
   assign req_item.func         = req_tuser;
   assign req_item.panel        = req_tdata[1:0];
   assign req_item.old_value    = req_tdata[5:2];
   assign req_item.new_value    = req_tdata[9:6];
   assign req_item.frame_number = req_tdata[13:10];

   // Move the pipe when the result register is free or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance || !item_valid_ff;
   assign req_take   = req_tvalid && req_tready;

   assign item_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : item_valid_ff);
   assign rsp_valid_in  = advance ? item_valid_ff : rsp_valid_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      if (req_take) begin
         item_ff <= req_item;
      end
   end

   dtr_render #(
      .PANEL_COUNT (PANEL_COUNT)
   ) u_render (
      .item   (item_ff),
      .result (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && item_valid_ff) begin
         result_ff <= result;
      end
   end

   // Pack the result beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, result_ff.rows[5], result_ff.rows[4], result_ff.rows[3],
                        result_ff.rows[2], result_ff.rows[1], result_ff.rows[0],
                        result_ff.panel_out};

endmodule

@@ src/dtr_checker.sv @@
// ----------------------------------------------------------------------------
// dtr_checker
// Port-level checks for the digit transition renderer, bound to the top level.
// ----------------------------------------------------------------------------
module dtr_checker #(
   parameter int PANEL_COUNT = dtr_pkg::PANEL_COUNT_DEFAULT
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [dtr_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic [dtr_pkg::FUNC_W-1:0]      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [dtr_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // Pixel bits outside font columns 6 to 2, plus the byte padding
   localparam logic [dtr_pkg::RSP_TDATA_W-1:0] SPARE_BITS =
      (dtr_pkg::RSP_TDATA_W'({6{8'h83}}) << 2) | {6'h3F, 50'd0};

   // A stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // Reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Input side keeps flowing whenever the output side is not stalled
   assert property (@(posedge clock) !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("request stalled while result side is free");

   // Pixels only in font columns
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata & SPARE_BITS) == '0)
      else $error("pixel outside font columns");

   // Panels not fitted stay dark
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (32'(rsp_tdata[1:0]) >= PANEL_COUNT) |-> rsp_tdata[49:2] == '0)
      else $error("absent panel drawn");

endmodule

bind digit_transition_renderer_core dtr_checker #(
   .PANEL_COUNT (PANEL_COUNT)
) u_dtr_checker (.*);
